// ===== sv/lsm_pkg.sv =====
// Shared constants and types of the LRU slot list manager.
package lsm_pkg;

	// Slot indexes are 11 bits wide on the ports; slot 0 is the null link.
	localparam int unsigned SLOT_W = 11;
	localparam int unsigned SLOTS = 1024;
	localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOTS);

	localparam int unsigned BATCH_W = 7;
	localparam int unsigned MAX_BATCH_DEF = 64;
	localparam logic [BATCH_W-1:0] BATCH_RESET = 7'd64;

	localparam logic FUNC_TOUCH = 1'b0;
	localparam logic FUNC_EVICT = 1'b1;

	// One list entry: in-use flag and the two links.
	typedef struct packed {
		logic used;
		logic [SLOT_W-1:0] older;
		logic [SLOT_W-1:0] newer;
	} entry_t;

	// Access request to the link store: one write and one read per cycle.
	typedef struct packed {
		logic we;
		logic [SLOT_W-1:0] waddr;
		entry_t wdata;
		logic [SLOT_W-1:0] raddr;
	} mem_req_t;

endpackage

// ===== sv/lsm_link_store.sv =====
// Link memory of the slot list with write-to-read forwarding and a clearing pass.
module lsm_link_store (
	input  logic              clk,
	input  logic              arst_n,
	input  lsm_pkg::mem_req_t req,
	output lsm_pkg::entry_t   rdata,
	output logic              ready
);

	localparam int unsigned DEPTH = lsm_pkg::SLOTS + 1;

	lsm_pkg::entry_t mem_q [DEPTH];
	lsm_pkg::entry_t raw_q;
	lsm_pkg::entry_t fwd_data_q;
	logic fwd_q;
	logic clearing_q;
	logic [lsm_pkg::SLOT_W-1:0] clr_q;

	// After reset every entry is swept to zero, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q <= '0;
		end else if (clearing_q) begin
			if (clr_q == lsm_pkg::SLOT_MAX) begin
				clearing_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	// Entry 0 is the null link and is never written after the sweep.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_q[clr_q] <= '0;
		end else if (req.we && req.waddr != '0) begin
			mem_q[req.waddr] <= req.wdata;
		end
		raw_q <= mem_q[req.raddr];
		fwd_q <= req.we && !clearing_q && (req.waddr == req.raddr) && (req.waddr != '0);
		fwd_data_q <= req.wdata;
	end

	assign rdata = fwd_q ? fwd_data_q : raw_q;
	assign ready = !clearing_q;

endmodule

// ===== sv/lru_slot_list_manager_core.sv =====
// Top level of the LRU slot list manager: command sequencer over the link memory.
//
// Keeps least-recently-used order over slots 1..1024 as a doubly linked list.
// Commands enter on start/func/slot and are taken on a clock edge where start
// is high and busy is low. func 0 touches a slot (moves it to the newest end),
// func 1 evicts up to evict_batch of the oldest slots.
// Results leave on done, which is high for exactly one cycle per result beat;
// the receiver cannot stall, so every beat must be taken when shown.
// A touch gives one beat after one state per dependent read-modify-write of
// the link memory: S_TOUCH alone for a bad slot index, an empty list or the
// tail; S_TOUCH and S_APPEND for a new entry; S_TOUCH, S_HEAD and S_APPEND
// for the head; S_TOUCH, S_UNL_O and/or S_UNL_N and S_APPEND for a middle
// entry; its beat is registered from the last of those states. An evict
// gives one beat per freed slot on consecutive cycles, one per S_EVICT read
// of the next-newer link, then S_FIX clears a surviving head's back link. An
// empty list or zero batch evict gives its one beat the next cycle, busy low.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the
// evict batch size; cfg_ready is always high and writes belong in idle time.
// After reset the link memory is swept clear, one entry a cycle; busy is
// high during the sweep, while configuration writes are taken.
module lru_slot_list_manager_core #(
	parameter int unsigned MAX_BATCH = lsm_pkg::MAX_BATCH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [lsm_pkg::SLOT_W-1:0]  slot,
	output logic                        done,
	output logic [lsm_pkg::SLOT_W-1:0]  evicted_slot,
	output logic                        evicted_valid,
	output logic                        last,
	output logic [lsm_pkg::SLOT_W-1:0]  oldest_slot,
	output logic [lsm_pkg::SLOT_W-1:0]  entry_count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lsm_pkg::BATCH_W-1:0] cfg_data
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_TOUCH  = 8'b0000_0010,
		S_HEAD   = 8'b0000_0100,
		S_UNL_O  = 8'b0000_1000,
		S_UNL_N  = 8'b0001_0000,
		S_APPEND = 8'b0010_0000,
		S_EVICT  = 8'b0100_0000,
		S_FIX    = 8'b1000_0000
	} state_t;

	localparam logic [lsm_pkg::BATCH_W-1:0] BATCH_CAP = lsm_pkg::BATCH_W'(MAX_BATCH);

	state_t state_q, state_d;
	logic [lsm_pkg::SLOT_W-1:0] head_q, head_d;
	logic [lsm_pkg::SLOT_W-1:0] tail_q, tail_d;
	logic [lsm_pkg::SLOT_W-1:0] count_q, count_d;
	logic [lsm_pkg::BATCH_W-1:0] idx_q, idx_d;
	logic [lsm_pkg::BATCH_W-1:0] batch_q;
	logic [lsm_pkg::BATCH_W-1:0] eff_batch;
	logic [lsm_pkg::SLOT_W-1:0] s_q;
	logic [lsm_pkg::SLOT_W-1:0] o_q;
	logic [lsm_pkg::SLOT_W-1:0] n_q;
	logic [lsm_pkg::SLOT_W-1:0] rd_addr_q;

	lsm_pkg::mem_req_t req;
	lsm_pkg::entry_t rdata;
	logic store_ready;

	logic accept;
	logic in_slot_ok;
	logic s_ok;
	logic fin;
	logic emit;
	logic emit_vld;
	logic emit_last;
	logic [lsm_pkg::SLOT_W-1:0] emit_slot;

	lsm_link_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata),
		.ready  (store_ready)
	);

	assign busy = (state_q != S_IDLE) || !store_ready;
	assign accept = start && !busy;
	assign cfg_ready = 1'b1;
	assign eff_batch = (batch_q > BATCH_CAP) ? BATCH_CAP : batch_q;
	assign in_slot_ok = (slot != '0) && (slot <= lsm_pkg::SLOT_MAX);
	assign s_ok = (s_q != '0) && (s_q <= lsm_pkg::SLOT_MAX);

	// Each state consumes the entry read in the previous cycle, writes it back
	// modified and issues the next dependent read; the store forwards a write
	// to a read of the same entry in the same cycle.
	always_comb begin
		state_d = state_q;
		head_d = head_q;
		tail_d = tail_q;
		count_d = count_q;
		idx_d = idx_q;
		req.we = 1'b0;
		req.waddr = rd_addr_q;
		req.wdata = rdata;
		req.raddr = '0;
		emit = 1'b0;
		emit_vld = 1'b0;
		emit_last = 1'b1;
		emit_slot = '0;
		fin = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (func == lsm_pkg::FUNC_TOUCH) begin
						req.raddr = in_slot_ok ? slot : '0;
						state_d = S_TOUCH;
					end else if (head_q == '0 || tail_q == '0) begin
						// Evict of an empty list resynchronizes the count.
						count_d = '0;
						emit = 1'b1;
					end else if (eff_batch == '0) begin
						emit = 1'b1;
					end else begin
						req.raddr = head_q;
						idx_d = '0;
						state_d = S_EVICT;
					end
				end
			end
			S_TOUCH: begin
				if (!s_ok) begin
					emit = 1'b1;
					state_d = S_IDLE;
				end else begin
					if (!rdata.used) begin
						count_d = count_q + 1'b1;
					end
					req.we = 1'b1;
					req.waddr = s_q;
					req.wdata.used = 1'b1;
					if (head_q == '0 || tail_q == '0) begin
						req.wdata.older = '0;
						req.wdata.newer = '0;
						head_d = s_q;
						tail_d = s_q;
						emit = 1'b1;
						state_d = S_IDLE;
					end else if (s_q == tail_q) begin
						emit = 1'b1;
						state_d = S_IDLE;
					end else begin
						req.wdata.older = tail_q;
						req.wdata.newer = '0;
						if (s_q == head_q) begin
							head_d = rdata.newer;
							req.raddr = rdata.newer;
							state_d = S_HEAD;
						end else if (rdata.older != '0) begin
							req.raddr = rdata.older;
							state_d = S_UNL_O;
						end else if (rdata.newer != '0) begin
							req.raddr = rdata.newer;
							state_d = S_UNL_N;
						end else begin
							req.raddr = tail_q;
							state_d = S_APPEND;
						end
					end
				end
			end
			S_HEAD: begin
				req.we = 1'b1;
				req.wdata.older = '0;
				req.raddr = tail_q;
				state_d = S_APPEND;
			end
			S_UNL_O: begin
				req.we = 1'b1;
				req.wdata.newer = n_q;
				if (n_q != '0) begin
					req.raddr = n_q;
					state_d = S_UNL_N;
				end else begin
					req.raddr = tail_q;
					state_d = S_APPEND;
				end
			end
			S_UNL_N: begin
				req.we = 1'b1;
				req.wdata.older = o_q;
				req.raddr = tail_q;
				state_d = S_APPEND;
			end
			S_APPEND: begin
				req.we = 1'b1;
				req.wdata.newer = s_q;
				tail_d = s_q;
				emit = 1'b1;
				state_d = S_IDLE;
			end
			S_EVICT: begin
				req.we = 1'b1;
				req.wdata = '0;
				head_d = rdata.newer;
				count_d = (count_q != '0) ? count_q - 1'b1 : '0;
				if (rdata.newer == '0) begin
					tail_d = '0;
					count_d = '0;
				end
				fin = (rdata.newer == '0) || (idx_q + 1'b1 == eff_batch);
				emit = 1'b1;
				emit_vld = 1'b1;
				emit_slot = rd_addr_q;
				emit_last = fin;
				req.raddr = rdata.newer;
				idx_d = idx_q + 1'b1;
				if (fin) begin
					state_d = (rdata.newer != '0) ? S_FIX : S_IDLE;
				end
			end
			S_FIX: begin
				// The surviving head loses its back link.
				req.we = 1'b1;
				req.wdata.older = '0;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			batch_q <= lsm_pkg::BATCH_RESET;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			count_q <= count_d;
			idx_q <= idx_d;
			done <= emit;
			if (cfg_valid && cfg_ready) begin
				batch_q <= cfg_data;
			end
		end
	end

	// Payload registers: command operands, unlink neighbors and the result beat.
	always_ff @(posedge clk) begin
		rd_addr_q <= req.raddr;
		if (accept) begin
			s_q <= slot;
		end
		if (state_q == S_TOUCH) begin
			o_q <= rdata.older;
			n_q <= rdata.newer;
		end
		if (emit) begin
			evicted_slot <= emit_slot;
			evicted_valid <= emit_vld;
			last <= emit_last;
			oldest_slot <= head_d;
			entry_count <= count_d;
		end
	end

`ifndef SYNTHESIS
	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!store_ready |-> !req.we)
		else $error("link memory written during the clearing sweep");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lsm_pkg::SLOT_MAX)
		else $error("entry count exceeds the number of slots");

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((head_q == '0) == (tail_q == '0)))
		else $error("head and tail disagree on an empty list");

	a_freed_slot_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted_valid) |-> (evicted_slot != '0))
		else $error("evict beat names the null slot");

	a_touch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == lsm_pkg::FUNC_TOUCH) |=> busy)
		else $error("touch accepted without the sequencer going busy");
`endif

endmodule

// ===== verif/lru_order_checker.sv =====
// Checker for the LRU slot list manager: keeps its own copy of the slot order and checks each beat.
module lru_order_checker #(
	parameter int unsigned MAX_BATCH = lsm_pkg::MAX_BATCH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        func,
	input  logic [lsm_pkg::SLOT_W-1:0]  slot,
	input  logic                        done,
	input  logic [lsm_pkg::SLOT_W-1:0]  evicted_slot,
	input  logic                        evicted_valid,
	input  logic                        last,
	input  logic [lsm_pkg::SLOT_W-1:0]  oldest_slot,
	input  logic [lsm_pkg::SLOT_W-1:0]  entry_count,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [lsm_pkg::BATCH_W-1:0] cfg_data,
	output int                          mismatches,
	output int                          waiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import lsm_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0] freed;
		logic              freed_valid;
		logic              final_beat;
		logic [SLOT_W-1:0] oldest;
		logic [SLOT_W-1:0] count;
	} lru_beat_t;

	logic [SLOT_W-1:0]  older_of [0:SLOTS];
	logic [SLOT_W-1:0]  newer_of [0:SLOTS];
	logic               in_use [0:SLOTS];
	logic [SLOT_W-1:0]  head;
	logic [SLOT_W-1:0]  tail;
	logic [SLOT_W-1:0]  used;
	logic [BATCH_W-1:0] batch_reg;
	lru_beat_t          beat_q [$];
	int                 fail_total = 0;

	assign mismatches = fail_total;

	task automatic report_mismatch(string msg);
		$display("%0t ns: %s", $time, msg);
		fail_total++;
	endtask

	function automatic void post_beat(logic [SLOT_W-1:0] s, logic v, logic fin);
		lru_beat_t b;
		b.freed = s;
		b.freed_valid = v;
		b.final_beat = fin;
		b.oldest = head;
		b.count = used;
		beat_q.push_back(b);
	endfunction

	function automatic void link_newest(logic [SLOT_W-1:0] s);
		older_of[s] = tail;
		newer_of[s] = '0;
		newer_of[tail] = s;
		tail = s;
	endfunction

	function automatic void move_to_newest(logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] o;
		logic [SLOT_W-1:0] n;
		if (s == '0 || s > SLOT_MAX)
			return;
		if (!in_use[s]) begin
			in_use[s] = 1'b1;
			used = used + 1'b1;
		end
		if (head == '0 || tail == '0) begin
			older_of[s] = '0;
			newer_of[s] = '0;
			head = s;
			tail = s;
		end else if (s == tail) begin
			// Already the newest entry.
		end else if (s == head) begin
			head = newer_of[s];
			older_of[head] = '0;
			link_newest(s);
		end else begin
			o = older_of[s];
			n = newer_of[s];
			if (o != '0)
				newer_of[o] = n;
			if (n != '0)
				older_of[n] = o;
			link_newest(s);
		end
		older_of[0] = '0;
		newer_of[0] = '0;
	endfunction

	function automatic void evict_oldest();
		int unsigned lim;
		logic [SLOT_W-1:0] d;
		lim = (batch_reg > MAX_BATCH) ? MAX_BATCH : batch_reg;
		if (head == '0 || tail == '0) begin
			used = '0;
			post_beat('0, 1'b0, 1'b1);
			return;
		end
		if (lim == 0) begin
			post_beat('0, 1'b0, 1'b1);
			return;
		end
		for (int i = 0; i < lim; i++) begin
			d = head;
			head = newer_of[d];
			older_of[d] = '0;
			newer_of[d] = '0;
			in_use[d] = 1'b0;
			if (used != '0)
				used = used - 1'b1;
			if (head == '0) begin
				tail = '0;
				used = '0;
			end
			post_beat(d, 1'b1, head == '0 || i + 1 == lim);
			if (head == '0)
				break;
		end
		if (head != '0)
			older_of[head] = '0;
	endfunction

	// Beats are checked before a new command is predicted: a beat shown at this
	// edge always belongs to a command taken at an earlier edge.
	always @(posedge clk or negedge arst_n) begin : watch
		lru_beat_t b;
		if (!arst_n) begin
			for (int i = 0; i <= SLOTS; i++) begin
				older_of[i] = '0;
				newer_of[i] = '0;
				in_use[i] = 1'b0;
			end
			head = '0;
			tail = '0;
			used = '0;
			batch_reg = BATCH_RESET;
			beat_q.delete();
			waiting <= 0;
		end else begin
			if (done) begin
				if (beat_q.size() == 0) begin
					report_mismatch($sformatf("beat with nothing expected, evicted_slot %0d",
						evicted_slot));
				end else begin
					b = beat_q.pop_front();
					if (evicted_slot !== b.freed)
						report_mismatch($sformatf("evicted_slot expected %0d, got %0d",
							b.freed, evicted_slot));
					if (evicted_valid !== b.freed_valid)
						report_mismatch($sformatf("evicted_valid expected %0d, got %0d",
							b.freed_valid, evicted_valid));
					if (last !== b.final_beat)
						report_mismatch($sformatf("last expected %0d, got %0d",
							b.final_beat, last));
					if (oldest_slot !== b.oldest)
						report_mismatch($sformatf("oldest_slot expected %0d, got %0d",
							b.oldest, oldest_slot));
					if (entry_count !== b.count)
						report_mismatch($sformatf("entry_count expected %0d, got %0d",
							b.count, entry_count));
				end
			end
			if (cfg_valid && cfg_ready)
				batch_reg = cfg_data;
			if (start && !busy) begin
				if (func == FUNC_EVICT) begin
					evict_oldest();
				end else begin
					move_to_newest(slot);
					post_beat('0, 1'b0, 1'b1);
				end
			end
			waiting <= beat_q.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// Top of the LRU slot list manager testbench: clock, reset, command stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lsm_pkg::*;

	// The slowest correct run is far below this: about 480 commands, each at
	// most 64 beats plus an idle burst, and the clearing sweep.
	localparam int unsigned CYCLE_LIMIT = 400_000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               func;
	logic [SLOT_W-1:0]  slot;
	logic               done;
	logic [SLOT_W-1:0]  evicted_slot;
	logic               evicted_valid;
	logic               last;
	logic [SLOT_W-1:0]  oldest_slot;
	logic [SLOT_W-1:0]  entry_count;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [BATCH_W-1:0] cfg_data;
	int                 mismatches;
	int                 waiting;

	// Chance in percent that a command is preceded by an idle burst.
	int unsigned        idle_pct;
	int unsigned        cycles = 0;

	always #5ns clk = ~clk;

	lru_slot_list_manager_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.slot          (slot),
		.done          (done),
		.evicted_slot  (evicted_slot),
		.evicted_valid (evicted_valid),
		.last          (last),
		.oldest_slot   (oldest_slot),
		.entry_count   (entry_count),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// The checker sees the same ports as the block, predicts every beat and
	// hands back its mismatch count and the number of beats still owed.
	lru_order_checker order_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.slot          (slot),
		.done          (done),
		.evicted_slot  (evicted_slot),
		.evicted_valid (evicted_valid),
		.last          (last),
		.oldest_slot   (oldest_slot),
		.entry_count   (entry_count),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.waiting       (waiting)
	);

	// A hung handshake or a beat that never comes ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Sends one command. Inputs change on the falling edge; the command is
	// taken on the first rising edge with busy low. start stays high after
	// that, so the next call either raises a new command at once (back to
	// back) or lowers start for an idle burst.
	task automatic issue(logic f, logic [SLOT_W-1:0] s);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			@(negedge clk) start <= 1'b0;
			repeat ($urandom_range(9)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		func <= f;
		slot <= s;
		do @(posedge clk); while (busy);
	endtask

	// Writes the evict batch size once the block is idle: every owed beat has
	// come and busy is low. A further wait then covers the clear of the new
	// head's back link that follows the last beat of an evict.
	task automatic set_batch(logic [BATCH_W-1:0] v);
		@(negedge clk) start <= 1'b0;
		while (waiting != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	initial begin
		// Per phase: batch size, touch pool, evict chance, length and idling.
		// The phase with the widest pool and no random evicts grows the list
		// past 64 entries so that its closing evict runs a saturated batch.
		logic [BATCH_W-1:0] phase_batch [8] = '{7'd2, 7'd64, 7'd1, 7'd127,
			7'd3, 7'd0, 7'd17, 7'd100};
		int unsigned phase_pool [8] = '{12, 40, 8, 300, 20, 10, 60, 30};
		int unsigned phase_evict [8] = '{15, 10, 25, 0, 20, 15, 8, 12};
		int unsigned phase_items [8] = '{60, 60, 50, 100, 60, 40, 60, 50};
		int unsigned phase_idle [8] = '{35, 0, 35, 35, 0, 35, 35, 0};
		int unsigned r;
		logic [SLOT_W-1:0] pick;
		logic [SLOT_W-1:0] newest;

		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_TOUCH;
		slot = '0;
		cfg_valid = 1'b0;
		cfg_data = BATCH_RESET;
		newest = '0;
		idle_pct = 20;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed part, batch at its reset value of 64. An evict of the empty
		// list comes first, with the slot field ignored even at all ones.
		issue(FUNC_EVICT, '0);
		issue(FUNC_EVICT, 11'd2047);
		// Slot zero and slots above the table change nothing.
		issue(FUNC_TOUCH, '0);
		issue(FUNC_TOUCH, 11'd2047);
		issue(FUNC_TOUCH, 11'd1025);
		// First entry, then a touch of the tail, then new entries appended.
		issue(FUNC_TOUCH, 11'd1);
		issue(FUNC_TOUCH, 11'd1);
		issue(FUNC_TOUCH, 11'd1024);
		issue(FUNC_TOUCH, 11'd5);
		issue(FUNC_TOUCH, 11'd3);
		// Order is 1 1024 5 3: move the head, a middle entry, the tail, the
		// head again and one more middle entry.
		issue(FUNC_TOUCH, 11'd1);
		issue(FUNC_TOUCH, 11'd5);
		issue(FUNC_TOUCH, 11'd5);
		issue(FUNC_TOUCH, 11'd1024);
		issue(FUNC_TOUCH, 11'd1);
		// Fewer entries than the batch: the walk stops when the list runs dry.
		issue(FUNC_EVICT, '0);

		// A zero batch frees nothing even with entries present.
		set_batch(7'd0);
		issue(FUNC_TOUCH, 11'd2);
		issue(FUNC_EVICT, '0);
		// The largest register value saturates to the maximum batch.
		set_batch(7'd127);
		issue(FUNC_TOUCH, 11'd7);
		issue(FUNC_TOUCH, 11'd9);
		issue(FUNC_EVICT, '0);
		// Batch of one: the first evict leaves an entry behind and clears the
		// new head's back link, the second one empties the list.
		set_batch(7'd1);
		issue(FUNC_TOUCH, 11'd4);
		issue(FUNC_TOUCH, 11'd6);
		issue(FUNC_EVICT, '0);
		issue(FUNC_EVICT, '0);

		// Random part. Touches mostly hit a small pool so that head, middle and
		// tail moves are frequent; some repeat the last touched slot (usually
		// the tail) and some span the whole field including invalid slots.
		// Each phase closes with an evict.
		for (int p = 0; p < 8; p++) begin
			set_batch(phase_batch[p]);
			idle_pct = phase_idle[p];
			for (int n = 0; n < phase_items[p]; n++) begin
				r = $urandom_range(99);
				if (n == phase_items[p] - 1 || r < phase_evict[p]) begin
					issue(FUNC_EVICT, SLOT_W'($urandom_range(2047)));
				end else begin
					if (r < phase_evict[p] + 10)
						pick = SLOT_W'($urandom_range(2047));
					else if (r < phase_evict[p] + 25)
						pick = newest;
					else
						pick = SLOT_W'($urandom_range(phase_pool[p], 1));
					newest = pick;
					issue(FUNC_TOUCH, pick);
				end
			end
		end

		// Drain: wait for every owed beat, then let the block settle.
		@(negedge clk) start <= 1'b0;
		while (waiting != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
